/* rtl/lfukvc_pkg.sv */
// shared types and constants for the lfu key/value cache
`timescale 1ns / 1ps

package lfukvc_pkg;

    localparam int unsigned CFG_BITS  = 5;
    localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the request and clear the scan trackers
        logic rd_en;    // read one entry at the scan address
        logic commit;   // write back, update flags and present the result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_dp_status;

endpackage

/* rtl/lfukvc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lfukvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lfukvc_dp.sv */
// datapath: entry ram, valid flags, scan trackers, write-back and result register
`timescale 1ns / 1ps

module lfukvc_dp #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lfukvc_pkg::t_dp_cmd               i_cmd,
    output lfukvc_pkg::t_dp_status            o_status,
    input  logic [$clog2(ENTRIES)-1:0]        i_addr,
    input  logic                              i_cfg_we,
    input  logic [lfukvc_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                              i_kind,
    input  logic [KEY_BITS-1:0]               i_key,
    input  logic signed [VALUE_BITS-1:0]      i_write_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic signed [VALUE_BITS-1:0]      o_read_value,
    output logic                              o_evicted,
    output logic [KEY_BITS-1:0]               o_evicted_key
);

    import lfukvc_pkg::*;

    localparam int AW   = $clog2(ENTRIES);
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = ((OW > CFG_BITS) ? OW : CFG_BITS) + 1;
    localparam int DW   = KEY_BITS + VALUE_BITS + COUNT_BITS;

    // configuration and bookkeeping
    logic [CFG_BITS-1:0]   r_cap;
    logic [OW-1:0]         r_occ;
    logic [ENTRIES-1:0]    r_valid;

    // latched request
    logic                  r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_wval;

    // scan pipeline
    logic                  r_data_vld;
    logic [AW-1:0]         r_addr_q;

    // scan trackers
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_vic_found;
    logic [AW-1:0]         r_vic_idx;
    logic [KEY_BITS-1:0]   r_vic_key;
    logic [COUNT_BITS-1:0] r_vic_cnt;
    logic                  r_inv_found;
    logic [AW-1:0]         r_inv_idx;

    // result register
    logic                  r_out_valid;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_read_value;
    logic                  r_evicted;
    logic [KEY_BITS-1:0]   r_evicted_key;

    logic [DW-1:0]         ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  rd_v;
    logic                  vic_better;

    logic [CMPW-1:0]       eff_cap;
    logic                  over_cap;
    logic                  do_evict;
    logic                  do_insert;
    logic [AW-1:0]         slot;
    logic [ENTRIES-1:0]    evict_mask;
    logic [ENTRIES-1:0]    insert_mask;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;

    lfukvc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[DW-1 -: KEY_BITS];
    assign rd_val = ram_rdata[COUNT_BITS +: VALUE_BITS];
    assign rd_cnt = ram_rdata[COUNT_BITS-1:0];
    assign rd_v   = r_valid[r_addr_q];

    // lowest count wins, ties to the smaller key
    assign vic_better = !r_vic_found || (rd_cnt < r_vic_cnt) ||
                        ((rd_cnt == r_vic_cnt) && (rd_key < r_vic_key));

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMPW'(1);
        end else if (CMPW'(r_cap) > CMPW'(ENTRIES)) begin
            eff_cap = CMPW'(ENTRIES);
        end else begin
            eff_cap = CMPW'(r_cap);
        end
    end

    assign over_cap  = CMPW'(r_occ) >= eff_cap;
    assign do_evict  = !r_hit && over_cap && r_vic_found;
    assign do_insert = do_evict || r_inv_found;

    // after an eviction the lowest free slot is the victim or an earlier hole
    always_comb begin
        if (do_evict) begin
            slot = (r_inv_found && (r_inv_idx < r_vic_idx)) ? r_inv_idx : r_vic_idx;
        end else begin
            slot = r_inv_idx;
        end
    end

    assign evict_mask  = do_evict  ? (ENTRIES'(1) << r_vic_idx) : '0;
    assign insert_mask = do_insert ? (ENTRIES'(1) << slot) : '0;

    assign cnt_inc = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + COUNT_BITS'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = {r_key, r_wval, {COUNT_BITS{1'b0}}};
        if (i_cmd.commit) begin
            if (r_hit) begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
                ram_wdata = {r_key, (r_kind == KIND_PUT) ? r_wval : r_hit_val, cnt_inc};
            end else if (r_kind == KIND_PUT) begin
                ram_we = do_insert;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_valid     <= '0;
            r_data_vld  <= 1'b0;
            r_hit       <= 1'b0;
            r_vic_found <= 1'b0;
            r_inv_found <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_data_vld <= i_cmd.rd_en;

            if (i_cmd.load) begin
                r_hit       <= 1'b0;
                r_vic_found <= 1'b0;
                r_inv_found <= 1'b0;
            end else if (r_data_vld) begin
                if (rd_v && (rd_key == r_key) && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (rd_v && vic_better) begin
                    r_vic_found <= 1'b1;
                end
                if (!rd_v && !r_inv_found) begin
                    r_inv_found <= 1'b1;
                end
            end

            if (i_cmd.commit && !r_hit && (r_kind == KIND_PUT)) begin
                // victim cleared first, then the new slot set
                r_valid <= (r_valid & ~evict_mask) | insert_mask;
                if (!do_evict && do_insert) begin
                    r_occ <= r_occ + OW'(1);
                end
            end

            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr_q <= i_addr;
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_wval <= i_write_value;
        end
        if (r_data_vld) begin
            if (rd_v && (rd_key == r_key) && !r_hit) begin
                r_hit_idx <= r_addr_q;
                r_hit_val <= rd_val;
                r_hit_cnt <= rd_cnt;
            end
            if (rd_v && vic_better) begin
                r_vic_idx <= r_addr_q;
                r_vic_key <= rd_key;
                r_vic_cnt <= rd_cnt;
            end
            if (!rd_v && !r_inv_found) begin
                r_inv_idx <= r_addr_q;
            end
        end
        if (i_cmd.commit) begin
            r_found       <= r_hit;
            r_read_value  <= (r_hit && (r_kind == KIND_GET)) ? r_hit_val : '0;
            r_evicted     <= do_evict && (r_kind == KIND_PUT);
            r_evicted_key <= (do_evict && (r_kind == KIND_PUT)) ? r_vic_key : '0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

/* rtl/lfukvc_ctrl.sv */
// controller: request handshake and scan sequencing over the entry ram
`timescale 1ns / 1ps

module lfukvc_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    output lfukvc_pkg::t_dp_cmd          o_cmd,
    input  lfukvc_pkg::t_dp_status       i_status,
    output logic [$clog2(ENTRIES)-1:0]   o_addr
);

    import lfukvc_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_addr     = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            // last read data is folded in this cycle
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_addr = r_addr;

endmodule

/* rtl/lfu_key_value_cache.sv */
// Fully associative key/value cache with least-frequently-used replacement.
//
// Request channel (i_in_valid / o_in_ready) carries i_kind (0 get, 1 put),
// i_key and i_write_value. Each transfer produces exactly one result on the
// result channel (o_out_valid / i_out_ready): o_found, o_read_value,
// o_evicted and o_evicted_key. Capacity is written through i_cfg_we and
// i_cfg_data; the user must write it only while the cache is idle, as the
// block does not enforce this; zero acts as one, values above ENTRIES act as ENTRIES.
// Each request walks every entry of the entry ram through its single read
// port, one entry per cycle, then passes a drain state and write-back; the
// controller returns to idle as the result is registered and only then
// takes the next request, so a new request is not taken before the
// previous one has left write-back.
// Reset clears all valid flags, the occupancy and the result valid flag and
// sets the capacity to 16; no clearing pass is needed.
// A stalled receiver holds the result; a finished request waits in write-back
// until the result register frees up, and a new request can be taken while
// the previous result still waits.
`timescale 1ns / 1ps

module lfu_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfukvc_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [KEY_BITS-1:0]               i_key,
    input  logic signed [VALUE_BITS-1:0]      i_write_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic signed [VALUE_BITS-1:0]      o_read_value,
    output logic                              o_evicted,
    output logic [KEY_BITS-1:0]               o_evicted_key
);

    import lfukvc_pkg::*;

    t_dp_cmd                    cmd;
    t_dp_status                 status;
    logic [$clog2(ENTRIES)-1:0] scan_addr;

    lfukvc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status),
        .o_addr     (scan_addr)
    );

    lfukvc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_addr        (scan_addr),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule

/* rtl/lfukvc_checker.sv */
// port-level checks for the lfu key/value cache, bound to the top level
`timescale 1ns / 1ps

module lfukvc_checker #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_found,
    input logic signed [VALUE_BITS-1:0] o_read_value,
    input logic                         o_evicted,
    input logic [KEY_BITS-1:0]          o_evicted_key
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_found) && $stable(o_read_value) &&
            $stable(o_evicted) && $stable(o_evicted_key))
        else $error("result changed while stalled");

    // only a put of a new key can evict
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> !o_found)
        else $error("eviction reported on a hit");

    a_evict_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_evicted_key == '0)
        else $error("evicted key set without eviction");

    // a transfer in means the cache is busy on the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

endmodule

bind lfu_key_value_cache lfukvc_checker #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_lfukvc_checker (.*);

/* tb/lfu_key_value_cache_tb.sv */
// self-checking testbench for the lfu key/value cache
`timescale 1ns / 1ps

localparam int CACHE_SLOTS = 16;

typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
} t_lookup_result;

// tracks cache contents and the results still owed by the block
class lfu_cache_tracker;
    logic        slot_used [CACHE_SLOTS];
    logic [31:0] slot_key [CACHE_SLOTS];
    logic [31:0] slot_value [CACHE_SLOTS];
    logic [15:0] slot_uses [CACHE_SLOTS];
    int          fill;
    logic [4:0]  cap_reg;
    t_lookup_result expected_q[$];
    int          failures;

    function new();
        foreach (slot_used[i]) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_uses[i]  = '0;
        end
        fill     = 0;
        cap_reg  = lfukvc_pkg::CAP_RESET;
        failures = 0;
    endfunction

    function void set_capacity(logic [4:0] value);
        cap_reg = value;
    endfunction

    function int pending_count();
        return expected_q.size();
    endfunction

    function void accept_request(logic kind, logic [31:0] key, logic [31:0] wval);
        t_lookup_result res;
        int hit;
        int victim;
        int slot;
        int eff_cap;
        res    = '0;
        hit    = -1;
        victim = -1;
        slot   = -1;
        foreach (slot_used[i])
            if (hit < 0 && slot_used[i] && slot_key[i] == key)
                hit = i;
        if (hit >= 0) begin
            res.found = 1'b1;
            if (slot_uses[hit] != 16'hffff)
                slot_uses[hit] = slot_uses[hit] + 16'd1;
            if (kind == lfukvc_pkg::KIND_PUT)
                slot_value[hit] = wval;
            else
                res.read_value = slot_value[hit];
        end else if (kind == lfukvc_pkg::KIND_PUT) begin
            // zero acts as one, anything past the array size as the array size
            eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > CACHE_SLOTS) ? CACHE_SLOTS : cap_reg);
            if (fill >= eff_cap) begin
                // lowest use count, ties to the smallest key
                foreach (slot_used[i])
                    if (slot_used[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                        (slot_uses[i] == slot_uses[victim] &&
                         slot_key[i] < slot_key[victim])))
                        victim = i;
                if (victim >= 0) begin
                    res.evicted       = 1'b1;
                    res.evicted_key   = slot_key[victim];
                    slot_used[victim] = 1'b0;
                    fill = fill - 1;
                end
            end
            foreach (slot_used[i])
                if (slot < 0 && !slot_used[i])
                    slot = i;
            if (slot >= 0) begin
                slot_used[slot]  = 1'b1;
                slot_key[slot]   = key;
                slot_value[slot] = wval;
                slot_uses[slot]  = '0;
                fill = fill + 1;
            end
        end
        expected_q.push_back(res);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
        failures = failures + 1;
        if (failures <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_response(logic found, logic [31:0] rval, logic ev, logic [31:0] ekey);
        t_lookup_result want;
        if (expected_q.size() == 0) begin
            report("result with nothing outstanding", 32'd0, 32'd1);
            return;
        end
        want = expected_q.pop_front();
        if (found !== want.found)
            report("found", 32'(want.found), 32'(found));
        if (rval !== want.read_value)
            report("read_value", want.read_value, rval);
        if (ev !== want.evicted)
            report("evicted", 32'(want.evicted), 32'(ev));
        if (ekey !== want.evicted_key)
            report("evicted_key", want.evicted_key, ekey);
    endfunction
endclass

module lfu_key_value_cache_tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [4:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = lfukvc_pkg::KIND_GET;
    logic [31:0]        i_key = '0;
    logic signed [31:0] i_write_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_found;
    logic signed [31:0] o_read_value;
    logic               o_evicted;
    logic [31:0]        o_evicted_key;

    lfu_cache_tracker tracker;
    logic [31:0] key_pool [24];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_requests = 0;
    int hold_off_served = 0;
    int hold_left = 0;

    lfu_key_value_cache u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("lfu_key_value_cache test failed");
        $finish;
    end

    // result side: check each transfer, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_response(o_found, o_read_value, o_evicted, o_evicted_key);
        if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic kind, input logic [31:0] key,
                                input logic [31:0] wval);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_key         <= key;
        i_write_value <= wval;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.accept_request(kind, key, wval);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge i_clk);
    endtask

    // only called with the cache idle
    task automatic write_capacity(input logic [4:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_capacity(value);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(99, 0) < 88)
            return key_pool[$urandom_range(23, 0)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(19, 0))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_capacity();
        case ($urandom_range(7, 0))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd2;
            3: return 5'd16;
            4: return 5'd31;
            5: return 5'd17;
            default: return 5'($urandom_range(31, 1));
        endcase
    endfunction

    task automatic run_random_phase(input int items, input logic [4:0] first_cap,
                                    input bit with_pressure);
        logic kind;
        wait_for_results();
        write_capacity(first_cap);
        for (int n = 0; n < items; n++) begin
            if (n > 0 && n % 50 == 0) begin
                wait_for_results();
                write_capacity(pick_capacity());
            end
            if (with_pressure && n == 70)
                hold_off_requests = hold_off_requests + 1;
            if (with_pressure && n == 120)
                wait_for_results();
            kind = ($urandom_range(1, 0) == 1) ? lfukvc_pkg::KIND_PUT : lfukvc_pkg::KIND_GET;
            send_request(kind, pick_key(), pick_value());
        end
    endtask

    initial begin
        tracker = new();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        key_pool[2] = 32'haaaa_aaaa;
        key_pool[3] = 32'h5555_5555;
        for (int k = 4; k < 24; k++)
            key_pool[k] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 83;

        // directed: empty lookup, value extremes, update, evictions and ties
        write_capacity(5'd2);
        send_request(lfukvc_pkg::KIND_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(lfukvc_pkg::KIND_PUT, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_0000, 32'h8000_0000);
        send_request(lfukvc_pkg::KIND_GET, 32'hffff_ffff, 32'h0000_0000);
        send_request(lfukvc_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(lfukvc_pkg::KIND_GET, 32'hffff_ffff, 32'hffff_ffff);
        send_request(lfukvc_pkg::KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_0005, 32'h0000_0000);
        // zero capacity behaves as one, with occupancy above it
        wait_for_results();
        write_capacity(5'd0);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_0007, 32'h0000_0001);
        send_request(lfukvc_pkg::KIND_GET, 32'h0000_0007, 32'h0000_0000);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_0008, 32'h0000_0002);
        send_request(lfukvc_pkg::KIND_GET, 32'hffff_ffff, 32'h0000_0000);
        // two zero-count entries: the smaller key goes
        wait_for_results();
        write_capacity(5'd3);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_0009, 32'h1234_5678);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_000a, 32'hdead_beef);
        send_request(lfukvc_pkg::KIND_GET, 32'h0000_0005, 32'h0000_0000);
        send_request(lfukvc_pkg::KIND_GET, 32'h0000_0009, 32'h0000_0000);

        run_random_phase(200, 5'd31, 1'b0);

        send_idle_pct = 83;
        recv_idle_pct = 25;
        run_random_phase(200, 5'd1, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(200, 5'd16, 1'b0);

        // raise one key's use count, then make it compete
        wait_for_results();
        write_capacity(5'd16);
        send_request(lfukvc_pkg::KIND_PUT, 32'h0000_0000, 32'h0bad_cafe);
        repeat (20)
            send_request(lfukvc_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);
        wait_for_results();
        write_capacity(5'd1);
        repeat (6)
            send_request(lfukvc_pkg::KIND_PUT, $urandom, pick_value());
        send_request(lfukvc_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000);

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_count() == 0)
            $display("lfu_key_value_cache test passed");
        else
            $display("lfu_key_value_cache test failed");
        $finish;
    end

endmodule
